// ----- sv/lds_pkg.sv -----
// Shared widths, register indexes, reset values and types for the Langevin site step.
package lds_pkg;

	// Field and register widths
	localparam int DATA_W       = 32;
	localparam int FRAC_W       = 24;
	localparam int NOISE_W      = 16;
	localparam int NOISE_FRAC_W = 12;
	localparam int DAMP_W       = 31;
	localparam int DT_W         = 25;
	localparam int STIFF_W      = 31;
	localparam int GAIN_W       = 31;
	localparam int CFG_IDX_W    = 8;
	localparam int CFG_DATA_W   = 31;

	// Internal sum widths, sized to the largest magnitude each can reach
	localparam int NP_W  = 35;
	localparam int PN_W  = 43;
	localparam int VN_W  = 37;
	localparam int X3_W  = 48;
	localparam int ACC_W = 57;
	localparam int NV_W  = 60;

	// 1.0 in signed Q8.24, the upper limit of the time ramp
	localparam logic signed [DATA_W-1:0] ONE_Q = 32'sd16777216;

	// Register reset values
	localparam logic [DAMP_W-1:0]  DAMP_RST  = 31'd16777216;
	localparam logic [DT_W-1:0]    DT_RST    = 25'd134218;
	localparam logic [STIFF_W-1:0] STIFF_RST = 31'd67108864;
	localparam logic [GAIN_W-1:0]  GAIN_RST  = 31'd474531;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DAMPING      = 8'd0,
		REG_TIME_STEP    = 8'd1,
		REG_STIFFNESS_SQ = 8'd2,
		REG_NOISE_GAIN   = 8'd3
	} reg_idx_t;

	// Current register contents, seen by the datapath
	typedef struct packed {
		logic [DAMP_W-1:0]  damping;
		logic [DT_W-1:0]    time_step;
		logic [STIFF_W-1:0] stiffness_sq;
		logic [GAIN_W-1:0]  noise_gain;
	} cfg_t;

	// Last datapath stage: unsaturated sums with their valid bit
	typedef struct packed {
		logic                   valid;
		logic signed [NP_W-1:0] np;
		logic signed [NV_W-1:0] nv;
	} pipe_out_t;

endpackage

// ----- sv/lds_cfg.sv -----
// Configuration register file of the Langevin site step.
module lds_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [lds_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lds_pkg::CFG_DATA_W-1:0] cfg_data,
	output lds_pkg::cfg_t                cfg
);
	import lds_pkg::*;

	cfg_t cfg_q;

	// Take a write on its index; drop writes beyond the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.damping      <= DAMP_RST;
			cfg_q.time_step    <= DT_RST;
			cfg_q.stiffness_sq <= STIFF_RST;
			cfg_q.noise_gain   <= GAIN_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DAMPING:      cfg_q.damping      <= cfg_data[DAMP_W-1:0];
				REG_TIME_STEP:    cfg_q.time_step    <= cfg_data[DT_W-1:0];
				REG_STIFFNESS_SQ: cfg_q.stiffness_sq <= cfg_data[STIFF_W-1:0];
				REG_NOISE_GAIN:   cfg_q.noise_gain   <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/lds_pipe.sv -----
// Eight-stage arithmetic pipeline of the Euler-Maruyama site update.
module lds_pipe (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic signed [lds_pkg::DATA_W-1:0]  position,
	input  logic signed [lds_pkg::DATA_W-1:0]  velocity,
	input  logic signed [lds_pkg::NOISE_W-1:0] noise_sample,
	input  logic signed [lds_pkg::DATA_W-1:0]  sim_time,
	input  lds_pkg::cfg_t                    cfg,
	output lds_pkg::pipe_out_t               result
);
	import lds_pkg::*;

	// Valid bits travel alongside the data
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	// Stage 1: captured inputs
	logic signed [DATA_W-1:0]  x_s1, v_s1, t_s1;
	logic signed [NOISE_W-1:0] nz_s1;

	// Stage 2: first-level products
	logic signed [DATA_W-1:0] x_s2, v_s2;
	logic signed [63:0]       xx_s2, ev_s2, rx_s2;
	logic signed [57:0]       dv_s2;
	logic signed [47:0]       gn_s2;

	// Stage 3: partial products of x*x2, plus the linear sums
	logic signed [56:0]     xl_s3;
	logic signed [47:0]     xh_s3;
	logic signed [NP_W-1:0] np_s3, np_s4, np_s5, np_s6, np_s7, np_s8;
	logic signed [PN_W-1:0] pn_s3, pn_s4, pn_s5;
	logic signed [VN_W-1:0] vn_s3, vn_s4, vn_s5, vn_s6, vn_s7;

	// Stage 4..8: cube, acceleration and final velocity sum
	logic signed [X3_W-1:0]  x3_s4;
	logic [54:0]             cl_s5;
	logic signed [55:0]      ch_s5;
	logic signed [ACC_W-1:0] acc_s6;
	logic [48:0]             pl_s7;
	logic signed [58:0]      ph_s7;
	logic signed [NV_W-1:0]  nv_s8;

	// Combinational signals between stages
	logic signed [DATA_W-1:0] ramp;
	logic signed [31:0]       damp_sx, gain_sx, stiff_sx;
	logic signed [25:0]       dt_sx;
	logic [38:0]              x2;
	logic signed [24:0]       x2_lo;
	logic signed [15:0]       x2_hi;
	logic signed [33:0]       dv_fl;
	logic signed [39:0]       ev_fl, rx_fl;
	logic signed [35:0]       noise_fl;
	logic signed [32:0]       xl_fl;
	logic signed [23:0]       x3_hi;
	logic signed [31:0]       cl_fl;
	logic signed [32:0]       acc_hi;
	logic signed [25:0]       pl_fl;

	// Registers as signed operands with a zero sign bit
	assign damp_sx  = {1'b0, cfg.damping};
	assign gain_sx  = {1'b0, cfg.noise_gain};
	assign stiff_sx = {1'b0, cfg.stiffness_sq};
	assign dt_sx    = {1'b0, cfg.time_step};

	// Clip the time to 1.0 for the time ramp
	assign ramp = (t_s1 < ONE_Q) ? t_s1 : ONE_Q;

	// Floor to Q8.24 by dropping fraction bits; split x2 for the next product
	assign x2       = xx_s2[62:24];
	assign x2_lo    = {1'b0, x2[23:0]};
	assign x2_hi    = {1'b0, x2[38:24]};
	assign dv_fl    = dv_s2[57:24];
	assign ev_fl    = ev_s2[63:24];
	assign rx_fl    = rx_s2[63:24];
	assign noise_fl = gn_s2[47:12];
	assign xl_fl    = xl_s3[56:24];
	assign x3_hi    = x3_s4[47:24];
	assign cl_fl    = {1'b0, cl_s5[54:24]};
	assign acc_hi   = acc_s6[56:24];
	assign pl_fl    = {1'b0, pl_s7[48:24]};

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// Datapath registers; after the input capture, each stage holds one level of multiplies or adds
	always_ff @(posedge clk) begin
		// capture an item on its transfer
		if (in_valid) begin
			x_s1  <= position;
			v_s1  <= velocity;
			nz_s1 <= noise_sample;
			t_s1  <= sim_time;
		end
		// x*x, eta*v, dt*v, gain*noise, ramp*x
		x_s2  <= x_s1;
		v_s2  <= v_s1;
		xx_s2 <= x_s1 * x_s1;
		ev_s2 <= damp_sx * v_s1;
		dv_s2 <= dt_sx * v_s1;
		gn_s2 <= gain_sx * nz_s1;
		rx_s2 <= ramp * x_s1;
		// x*x2 in two halves; position sum, 3*ramp*x - eta*v, v + noise
		xl_s3 <= x_s2 * x2_lo;
		xh_s3 <= x_s2 * x2_hi;
		np_s3 <= x_s2 + dv_fl;
		pn_s3 <= (rx_fl <<< 1) + rx_fl - ev_fl;
		vn_s3 <= v_s2 + noise_fl;
		// x3 = floor(x*x2)
		x3_s4 <= xh_s3 + xl_fl;
		np_s4 <= np_s3;
		pn_s4 <= pn_s3;
		vn_s4 <= vn_s3;
		// w2*x3 in two halves
		cl_s5 <= cfg.stiffness_sq * x3_s4[23:0];
		ch_s5 <= stiff_sx * x3_hi;
		np_s5 <= np_s4;
		pn_s5 <= pn_s4;
		vn_s5 <= vn_s4;
		// acc = 3*ramp*x - eta*v - w2*x3
		acc_s6 <= pn_s5 - ch_s5 - cl_fl;
		np_s6  <= np_s5;
		vn_s6  <= vn_s5;
		// dt*acc in two halves
		pl_s7 <= cfg.time_step * acc_s6[23:0];
		ph_s7 <= dt_sx * acc_hi;
		np_s7 <= np_s6;
		vn_s7 <= vn_s6;
		// velocity sum
		nv_s8 <= vn_s7 + ph_s7 + pl_fl;
		np_s8 <= np_s7;
	end

	assign result.valid = vld_s8;
	assign result.np    = np_s8;
	assign result.nv    = nv_s8;

endmodule

// ----- sv/langevin_double_well_site_step_top.sv -----
// Top level of the Langevin double-well site step: config, pipeline and output stage.
//
// One Euler-Maruyama step of damped Langevin motion for one lattice site.
// Input channel: drive position, velocity, noise_sample and sim_time with
// start high; the item transfers at that rising edge, since busy stays low.
// A new site may be offered in every cycle.
// Output channel: done is high for one cycle with new_position,
// new_velocity and saturated; the result transfers at the edge ending that
// cycle. The receiver cannot hold results off and none is needed: the
// pipeline never stalls.
// The result passes the pipeline stages and then the output register before
// it is on the outputs. Throughput: one site per cycle through the
// eight-stage pipeline, whose stages hold the input capture, multiplies or adds.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// at an edge; write only while no site is in flight.
// Reset: arst_n clears all valid bits and loads the register defaults;
// items in flight are dropped.
module langevin_double_well_site_step_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [lds_pkg::DATA_W-1:0]  position,
	input  logic signed [lds_pkg::DATA_W-1:0]  velocity,
	input  logic signed [lds_pkg::NOISE_W-1:0] noise_sample,
	input  logic signed [lds_pkg::DATA_W-1:0]  sim_time,
	input  logic                               cfg_write,
	input  logic [lds_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lds_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                               done,
	output logic signed [lds_pkg::DATA_W-1:0]  new_position,
	output logic signed [lds_pkg::DATA_W-1:0]  new_velocity,
	output logic                               saturated
);
	import lds_pkg::*;

	cfg_t      cfg;
	pipe_out_t res;

	logic                     np_ovf, nv_ovf;
	logic signed [DATA_W-1:0] np_sat, nv_sat;

	logic                     done_q;
	logic signed [DATA_W-1:0] new_position_q, new_velocity_q;
	logic                     saturated_q;

	// Pipeline accepts every cycle
	assign busy = 1'b0;

	lds_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lds_pipe u_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start & ~busy),
		.position     (position),
		.velocity     (velocity),
		.noise_sample (noise_sample),
		.sim_time     (sim_time),
		.cfg          (cfg),
		.result       (res)
	);

	// Out of range when the bits above the result's sign differ from it
	assign np_ovf = (res.np[NP_W-1:DATA_W-1] != {(NP_W-DATA_W+1){res.np[NP_W-1]}});
	assign nv_ovf = (res.nv[NV_W-1:DATA_W-1] != {(NV_W-DATA_W+1){res.nv[NV_W-1]}});

	// Clip to the signed range, towards the side of the sign
	always_comb begin
		if (np_ovf) begin
			np_sat = {res.np[NP_W-1], {(DATA_W-1){~res.np[NP_W-1]}}};
		end else begin
			np_sat = res.np[DATA_W-1:0];
		end
		if (nv_ovf) begin
			nv_sat = {res.nv[NV_W-1], {(DATA_W-1){~res.nv[NV_W-1]}}};
		end else begin
			nv_sat = res.nv[DATA_W-1:0];
		end
	end

	// Strobe for one cycle per finished site
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res.valid;
		end
	end

	// Hold the saturated results for the strobe cycle
	always_ff @(posedge clk) begin
		if (res.valid) begin
			new_position_q <= np_sat;
			new_velocity_q <= nv_sat;
			saturated_q    <= np_ovf | nv_ovf;
		end
	end

	assign done         = done_q;
	assign new_position = new_position_q;
	assign new_velocity = new_velocity_q;
	assign saturated    = saturated_q;

endmodule

// ----- tb/site_step_checker.sv -----
// Checker for the Langevin site step: predicts each site update and compares the results.
module site_step_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic signed [lds_pkg::DATA_W-1:0]  position,
	input  logic signed [lds_pkg::DATA_W-1:0]  velocity,
	input  logic signed [lds_pkg::NOISE_W-1:0] noise_sample,
	input  logic signed [lds_pkg::DATA_W-1:0]  sim_time,
	input  logic                               cfg_write,
	input  logic [lds_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lds_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               done,
	input  logic signed [lds_pkg::DATA_W-1:0]  new_position,
	input  logic signed [lds_pkg::DATA_W-1:0]  new_velocity,
	input  logic                               saturated,
	input  logic                               end_of_test,
	output int                                 fail_count,
	output int                                 outstanding,
	output int                                 checked_count,
	output int                                 clipped_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import lds_pkg::*;

	localparam int MAX_PRINTED = 100;

	typedef struct packed {
		logic signed [DATA_W-1:0] pos;
		logic signed [DATA_W-1:0] vel;
		logic                     clip;
	} site_result_t;

	// Own copy of the register file
	logic [DAMP_W-1:0]  damping_q;
	logic [DT_W-1:0]    time_step_q;
	logic [STIFF_W-1:0] stiffness_q;
	logic [GAIN_W-1:0]  gain_q;

	site_result_t expected_sites[$];

	initial begin
		fail_count    = 0;
		outstanding   = 0;
		checked_count = 0;
		clipped_count = 0;
	end

	// Print one line per mismatch (up to a cap) and count it
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (fail_count < MAX_PRINTED)
			$display("MISMATCH at %0t ns: %s, got %0h, want %0h", $time, what, got, want);
		fail_count++;
	endtask

	// Exact product of two Q8.24 values, floored back to Q8.24
	function automatic logic signed [127:0] q24_product(input logic signed [127:0] a,
			input logic signed [127:0] b);
		return (a * b) >>> FRAC_W;
	endfunction

	// One Euler-Maruyama step of a site under the current registers
	function automatic site_result_t advance_site(input logic signed [DATA_W-1:0] x_in,
			input logic signed [DATA_W-1:0] v_in, input logic signed [NOISE_W-1:0] nz_in,
			input logic signed [DATA_W-1:0] t_in);
		logic signed [127:0] x, v, nz, t, eta, dt, w2, gain;
		logic signed [127:0] x2, x3, cube, ramp, pull, acc, np, nv, hi, lo;
		site_result_t r;
		x    = x_in;
		v    = v_in;
		nz   = nz_in;
		t    = t_in;
		eta  = damping_q;
		dt   = time_step_q;
		w2   = stiffness_q;
		gain = gain_q;
		x2   = q24_product(x, x);
		x3   = q24_product(x, x2);
		cube = q24_product(w2, x3);
		// ramp follows t below 1.0, negative time included
		ramp = (t < ONE_Q) ? t : ONE_Q;
		pull = 3 * q24_product(x, ramp);
		acc  = -q24_product(eta, v) - cube + pull;
		np   = x + q24_product(dt, v);
		nv   = v + q24_product(dt, acc) + ((gain * nz) >>> NOISE_FRAC_W);
		// clip both sums to the signed result range
		hi     = (128'sd1 <<< (DATA_W - 1)) - 1;
		lo     = -hi - 1;
		r.clip = 1'b0;
		if (np > hi) begin
			np     = hi;
			r.clip = 1'b1;
		end else if (np < lo) begin
			np     = lo;
			r.clip = 1'b1;
		end
		if (nv > hi) begin
			nv     = hi;
			r.clip = 1'b1;
		end else if (nv < lo) begin
			nv     = lo;
			r.clip = 1'b1;
		end
		r.pos = np[DATA_W-1:0];
		r.vel = nv[DATA_W-1:0];
		return r;
	endfunction

	// Compare results, track register writes, predict accepted sites
	always @(posedge clk or negedge arst_n) begin : watch
		site_result_t want;
		if (!arst_n) begin
			damping_q   = DAMP_RST;
			time_step_q = DT_RST;
			stiffness_q = STIFF_RST;
			gain_q      = GAIN_RST;
			expected_sites.delete();
			outstanding = 0;
		end else begin
			// check a result transfer against the oldest prediction
			if (done === 1'b1) begin
				if (expected_sites.size() == 0) begin
					report_mismatch("result with no site pending", new_position, 0);
				end else begin
					want = expected_sites.pop_front();
					checked_count++;
					if (want.clip)
						clipped_count++;
					if (new_position !== want.pos)
						report_mismatch("new_position", new_position, want.pos);
					if (new_velocity !== want.vel)
						report_mismatch("new_velocity", new_velocity, want.vel);
					if (saturated !== want.clip)
						report_mismatch("saturated", saturated, want.clip);
				end
			end else if (done !== 1'b0) begin
				report_mismatch("done not at a known level", done, 0);
			end
			// follow register writes; indexes past the list are ignored
			if (cfg_write === 1'b1) begin
				case (cfg_index)
					REG_DAMPING:      damping_q   = cfg_data[DAMP_W-1:0];
					REG_TIME_STEP:    time_step_q = cfg_data[DT_W-1:0];
					REG_STIFFNESS_SQ: stiffness_q = cfg_data[STIFF_W-1:0];
					REG_NOISE_GAIN:   gain_q      = cfg_data[GAIN_W-1:0];
					default:          ;
				endcase
			end
			// predict the site accepted at this edge
			if (start === 1'b1 && busy === 1'b0)
				expected_sites.push_back(advance_site(position, velocity, noise_sample, sim_time));
			outstanding = expected_sites.size();
		end
	end

	// Flag predictions never answered by the end of the run
	always @(posedge end_of_test) begin
		if (expected_sites.size() != 0)
			report_mismatch("sites never answered", expected_sites.size(), 0);
	end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the Langevin site step: clock, reset, stimulus and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lds_pkg::*;

	localparam int CYCLE_LIMIT  = 100000;
	localparam int DRAIN_CYCLES = 16;

	// Indexes past the register list, written to check they are ignored
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 8'd4;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 8'hFF;

	localparam logic signed [DATA_W-1:0]  POS_MAX   = 32'sh7FFFFFFF;
	localparam logic signed [DATA_W-1:0]  POS_MIN   = 32'sh80000000;
	localparam logic signed [NOISE_W-1:0] NOISE_MAX = 16'sh7FFF;
	localparam logic signed [NOISE_W-1:0] NOISE_MIN = 16'sh8000;
	localparam logic signed [DATA_W-1:0]  HALF_Q    = ONE_Q >>> 1;
	localparam logic [30:0]               REG_MAX   = 31'h7FFFFFFF;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic signed [DATA_W-1:0]  position;
	logic signed [DATA_W-1:0]  velocity;
	logic signed [NOISE_W-1:0] noise_sample;
	logic signed [DATA_W-1:0]  sim_time;
	logic                      cfg_write;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;
	logic                      done;
	logic signed [DATA_W-1:0]  new_position;
	logic signed [DATA_W-1:0]  new_velocity;
	logic                      saturated;
	logic                      end_of_test;

	int fail_count;
	int outstanding;
	int checked_count;
	int clipped_count;
	int cycle_count;
	int settings_count;
	int quiet_left;

	langevin_double_well_site_step_top uut (.*);

	site_step_checker u_checker (.*);

	// Clock: 4 ns period
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Abort a hung run
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", cycle_count);
			$display("langevin_double_well_site_step_top regression: fail");
			$finish;
		end
	end

	// Offer one site after a random gap, hold it until the transfer
	task automatic offer_site(input logic signed [DATA_W-1:0] x,
			input logic signed [DATA_W-1:0] v, input logic signed [NOISE_W-1:0] nz,
			input logic signed [DATA_W-1:0] t);
		int gap;
		if (quiet_left > 0) begin
			gap = 0;
			quiet_left--;
		end else begin
			gap = $urandom_range(0, 3);
			if ($urandom_range(0, 19) == 0)
				quiet_left = $urandom_range(8, 32);
		end
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start        <= 1'b1;
		position     <= x;
		velocity     <= v;
		noise_sample <= nz;
		sim_time     <= t;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Random site: mostly lattice-like values, some across the full range
	task automatic random_site();
		logic signed [DATA_W-1:0]  x, v, t;
		logic signed [NOISE_W-1:0] nz;
		int                        mode;
		mode = $urandom_range(0, 9);
		nz   = NOISE_W'($urandom);
		if (mode < 2) begin
			x = $urandom;
			v = $urandom;
			t = $urandom;
		end else begin
			x = int'($urandom_range(0, 100663296)) - 50331648;
			v = int'($urandom_range(0, 134217728)) - 67108864;
			case (mode)
				2:       t = ONE_Q;
				3:       t = -int'($urandom_range(0, 16777216));
				default: t = int'($urandom_range(0, 33554432)) - 4194304;
			endcase
		end
		offer_site(x, v, nz, t);
	endtask

	// Extremes of every field, repeated under each register setting
	task automatic corner_sites();
		offer_site(POS_MAX, POS_MAX, NOISE_MAX, POS_MAX);
		offer_site(POS_MIN, POS_MIN, NOISE_MIN, POS_MIN);
		offer_site(POS_MAX, POS_MIN, NOISE_MIN, ONE_Q);
		offer_site(POS_MIN, POS_MAX, NOISE_MAX, -ONE_Q);
		offer_site('0, POS_MAX, NOISE_MAX, '0);
		offer_site('0, POS_MIN, NOISE_MIN, '0);
		offer_site(-32'sd1, -32'sd1, -16'sd1, -32'sd1);
		offer_site(ONE_Q, -ONE_Q, 16'sd4096, ONE_Q + 1);
	endtask

	// Drain the pipeline, then write all four registers and two spare indexes
	task automatic load_registers(input logic [DAMP_W-1:0] eta, input logic [DT_W-1:0] dt,
			input logic [STIFF_W-1:0] w2, input logic [GAIN_W-1:0] gain);
		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_DAMPING;
		cfg_data  <= eta;
		@(negedge clk);
		cfg_index <= REG_TIME_STEP;
		cfg_data  <= CFG_DATA_W'(dt);
		@(negedge clk);
		cfg_index <= REG_STIFFNESS_SQ;
		cfg_data  <= w2;
		@(negedge clk);
		cfg_index <= REG_NOISE_GAIN;
		cfg_data  <= gain;
		@(negedge clk);
		cfg_index <= IDX_SPARE_LO;
		cfg_data  <= REG_MAX;
		@(negedge clk);
		cfg_index <= IDX_SPARE_HI;
		cfg_data  <= REG_MAX;
		@(negedge clk);
		cfg_write <= 1'b0;
		settings_count++;
	endtask

	// Stimulus
	initial begin
		logic [DAMP_W-1:0]  eta_pick;
		logic [DT_W-1:0]    dt_pick;
		logic [STIFF_W-1:0] w2_pick;
		logic [GAIN_W-1:0]  gain_pick;
		arst_n         = 1'b0;
		start          = 1'b0;
		position       = '0;
		velocity       = '0;
		noise_sample   = '0;
		sim_time       = '0;
		cfg_write      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		end_of_test    = 1'b0;
		quiet_left     = 0;
		settings_count = 1;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed sites under the reset registers
		offer_site('0, '0, '0, '0);
		offer_site(ONE_Q, '0, '0, ONE_Q);
		offer_site(-ONE_Q, '0, '0, 2 * ONE_Q);
		offer_site(ONE_Q, '0, '0, -ONE_Q);
		offer_site(HALF_Q, -(HALF_Q >>> 1), 16'sd4096, '0);
		offer_site(-ONE_Q, ONE_Q, -16'sd4096, HALF_Q);
		offer_site('0, '0, NOISE_MAX, '0);
		offer_site('0, '0, NOISE_MIN, '0);
		offer_site(POS_MAX, '0, '0, '0);
		offer_site('0, POS_MAX, '0, ONE_Q);
		offer_site(3 * ONE_Q, -4 * ONE_Q, NOISE_MAX, POS_MIN);
		offer_site(-3 * ONE_Q, 4 * ONE_Q, NOISE_MIN, POS_MAX);
		offer_site(32'sd1, 32'sd1, 16'sd1, ONE_Q - 1);
		offer_site(-32'sd1, '0, '0, -32'sd1);
		corner_sites();
		repeat (200) random_site();

		// three registers at their maximum, the time step at 1.0
		load_registers(REG_MAX, DT_W'(ONE_Q), REG_MAX, REG_MAX);
		corner_sites();
		repeat (100) random_site();

		// all registers cleared
		load_registers('0, '0, '0, '0);
		corner_sites();
		repeat (100) random_site();

		// random settings, each pick physical or, with even odds, wider (full range; time step up to 1.0)
		repeat (6) begin
			eta_pick  = $urandom_range(0, 1) ? DAMP_W'($urandom)
				: DAMP_W'($urandom_range(0, 67108864));
			dt_pick   = $urandom_range(0, 1) ? DT_W'($urandom_range(0, 16777216))
				: DT_W'($urandom_range(0, 1048576));
			w2_pick   = $urandom_range(0, 1) ? STIFF_W'($urandom)
				: STIFF_W'($urandom_range(0, 134217728));
			gain_pick = $urandom_range(0, 1) ? GAIN_W'($urandom)
				: GAIN_W'($urandom_range(0, 33554432));
			load_registers(eta_pick, dt_pick, w2_pick, gain_pick);
			corner_sites();
			repeat (94) random_site();
		end

		// wait out the last results, then a drain period for strays
		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		end_of_test <= 1'b1;
		@(negedge clk);

		$display("Checked %0d site updates over %0d register settings, %0d of them clipped.",
			checked_count, settings_count, clipped_count);
		$display("Stimulus took in field extremes, negative and clamped time and spare writes.");
		if (fail_count == 0)
			$display("langevin_double_well_site_step_top regression: pass");
		else
			$display("langevin_double_well_site_step_top regression: fail");
		$finish;
	end

endmodule

// ----- langevin_double_well_site_step_top.f -----
sv/lds_pkg.sv
sv/lds_cfg.sv
sv/lds_pipe.sv
sv/langevin_double_well_site_step_top.sv
tb/site_step_checker.sv
tb/tb_top.sv
